[design/sorted_keyed_record_table_assert.svh]
// ----------------------------------------------------------------------------
// sorted keyed record table: assertion macros
// shared property forms for the table's concurrent checks
// ----------------------------------------------------------------------------
`ifndef SORTED_KEYED_RECORD_TABLE_ASSERT_SVH
`define SORTED_KEYED_RECORD_TABLE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SKRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SKRT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/skrt_pkg.sv]
// ----------------------------------------------------------------------------
// skrt_pkg
// types, codes and widths shared by the sorted keyed record table
// ----------------------------------------------------------------------------
`default_nettype none

package skrt_pkg;

  localparam int unsigned CAPACITY_DEF = 16;

  // field widths
  localparam int unsigned YEAR_W  = 16;
  localparam int unsigned AREA_W  = 20;
  localparam int unsigned SACKS_W = 24;
  localparam int unsigned PRICE_W = 20;
  localparam int unsigned VAL_W   = 40;

  // value per hectare arithmetic
  localparam int unsigned PROD_W  = PRICE_W + SACKS_W;
  localparam int unsigned SCALE_W = 7;
  localparam int unsigned NUM_W   = PROD_W + SCALE_W;
  localparam int unsigned SCALE   = 100;
  localparam int unsigned DCNT_W  = $clog2(NUM_W + 1);

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_DUMP   = 2'd2;

  // status codes
  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_DUP     = 3'd1;
  localparam logic [2:0] STAT_MISSING = 3'd2;
  localparam logic [2:0] STAT_FULL    = 3'd3;
  localparam logic [2:0] STAT_EMPTY   = 3'd4;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [YEAR_W-1:0]  year;
    logic [AREA_W-1:0]  area_hundredths;
    logic [SACKS_W-1:0] sack_count;
    logic [PRICE_W-1:0] sack_price_cents;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [YEAR_W-1:0]  out_year;
    logic [AREA_W-1:0]  out_area;
    logic [SACKS_W-1:0] out_sacks;
    logic [PRICE_W-1:0] out_price;
    logic [VAL_W-1:0]   value_per_area;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [AREA_W-1:0]  area;
    logic [SACKS_W-1:0] sacks;
    logic [PRICE_W-1:0] price;
    logic [VAL_W-1:0]   value;
  } rec_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_CMP,
    S_PLACE,
    S_SHCHK,
    S_SHRD,
    S_SHWR,
    S_FINISH,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_e;

endpackage

`default_nettype wire

[design/sorted_keyed_record_table.sv]
// ----------------------------------------------------------------------------
// sorted_keyed_record_table
// harvest records kept in ascending year order, unique years
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low; busy_o then stays
// high until the request is finished. Insert (cmd 0) and delete (cmd 1) give
// one result; dump (cmd 2) gives one result per stored record, the last one
// flagged, or a single table-empty result. Command 3 is dropped silently.
// Each result sits on res_o for one cycle with res_valid_o high; the receiver
// cannot hold it off, and none is repeated.
// Course of each command after the accepting edge:
//   insert: the result waits in S_FINISH until the value unit (product,
//           scale, quotient bits) is done; the search and the shift run
//           beside it
//   delete: the search runs to the match, or to the end when missing; when
//           found, each record behind it moves one place towards the gap
//   dump:   each record is read, then put out; an empty table answers in the
//           cycle after the request and busy_o never rises
// Reset empties the table; the memory itself is not cleared and needs no
// clearing pass, since only entries below the count are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_keyed_record_table
  import skrt_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic res_valid_o,
  output res_t res_o
);

  `include "sorted_keyed_record_table_assert.svh"

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e         state_q, state_d;
  req_t           req_q, req_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic [CW-1:0]  pos_q, pos_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [2:0]     stat_q, stat_d;
  rec_t           hold_q, hold_d;
  res_t           res_q, res_d;
  logic           res_valid_q, res_valid_d;

  logic           accept, is_ins, last_rec;
  logic [CW-1:0]  idx_inc, idx_dec, sh_src;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  rec_t           mem_wdata, mem_rdata;
  logic           div_start, div_busy;
  logic [VAL_W-1:0] div_value;

  assign accept   = start_i && (state_q == S_IDLE);
  assign is_ins   = (req_q.cmd == CMD_INSERT);
  assign idx_inc  = idx_q + 1'b1;
  assign idx_dec  = idx_q - 1'b1;
  assign sh_src   = is_ins ? idx_dec : idx_inc;
  assign last_rec = (idx_inc == cnt_q);

  // record memory
  skrt_store #(
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // value unit, used by inserts
  skrt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .area_i  (req_i.area_hundredths),
    .sacks_i (req_i.sack_count),
    .price_i (req_i.sack_price_cents),
    .busy_o  (div_busy),
    .value_o (div_value)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.cmd)
            CMD_INSERT, CMD_DELETE: state_d = S_SRCH;
            CMD_DUMP:               state_d = (cnt_q == '0) ? S_IDLE : S_DUMP_RD;
            default:                state_d = S_IDLE;
          endcase
        end
      end
      S_SRCH: begin
        if (idx_q == cnt_q) begin
          state_d = is_ins ? S_PLACE : S_FINISH;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (is_ins) begin
          if (mem_rdata.year < req_q.year) begin
            state_d = S_SRCH;
          end else if (mem_rdata.year == req_q.year) begin
            state_d = S_FINISH;
          end else begin
            state_d = S_PLACE;
          end
        end else begin
          state_d = (mem_rdata.year == req_q.year) ? S_SHCHK : S_SRCH;
        end
      end
      S_PLACE: begin
        state_d = (cnt_q == CW'(CAPACITY)) ? S_FINISH : S_SHCHK;
      end
      S_SHCHK: begin
        if (is_ins) begin
          state_d = (idx_q == pos_q) ? S_FINISH : S_SHRD;
        end else begin
          state_d = last_rec ? S_FINISH : S_SHRD;
        end
      end
      S_SHRD:     state_d = S_SHWR;
      S_SHWR:     state_d = S_SHCHK;
      S_FINISH: begin
        if (!(is_ins && div_busy)) begin
          state_d = S_IDLE;
        end
      end
      S_DUMP_RD:  state_d = S_DUMP_OUT;
      S_DUMP_OUT: state_d = last_rec ? S_IDLE : S_DUMP_RD;
      default:    state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_d       = req_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    stat_d      = stat_q;
    hold_d      = hold_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = idx_q[AW-1:0];
    mem_wdata   = mem_rdata;
    mem_raddr   = (state_q == S_SHRD) ? sh_src[AW-1:0] : idx_q[AW-1:0];
    div_start   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d  = req_i;
          idx_d  = '0;
          stat_d = STAT_OK;
          hold_d = '{year: req_i.year, area: '0, sacks: '0, price: '0, value: '0};
          if (req_i.cmd == CMD_INSERT) begin
            div_start    = 1'b1;
            hold_d.area  = req_i.area_hundredths;
            hold_d.sacks = req_i.sack_count;
            hold_d.price = req_i.sack_price_cents;
          end
          // empty dump answers straight from idle
          if (req_i.cmd == CMD_DUMP && cnt_q == '0) begin
            res_valid_d = 1'b1;
            res_d = '{status: STAT_EMPTY, out_year: req_i.year, out_area: '0,
                      out_sacks: '0, out_price: '0, value_per_area: '0, last: 1'b1};
          end
        end
      end
      S_SRCH: begin
        if (idx_q == cnt_q && !is_ins) begin
          stat_d = STAT_MISSING;
        end
      end
      S_CMP: begin
        if (is_ins) begin
          if (mem_rdata.year < req_q.year) begin
            idx_d = idx_inc;
          end else if (mem_rdata.year == req_q.year) begin
            stat_d = STAT_DUP;
          end
        end else if (mem_rdata.year == req_q.year) begin
          hold_d = mem_rdata;
        end else begin
          idx_d = idx_inc;
        end
      end
      S_PLACE: begin
        if (cnt_q == CW'(CAPACITY)) begin
          stat_d = STAT_FULL;
        end else begin
          pos_d = idx_q;
          idx_d = cnt_q;
        end
      end
      S_SHWR: begin
        // move one record one place towards the gap
        mem_we = 1'b1;
        idx_d  = sh_src;
      end
      S_FINISH: begin
        if (!(is_ins && div_busy)) begin
          res_valid_d = 1'b1;
          res_d = '{status: stat_q, out_year: req_q.year, out_area: hold_q.area,
                    out_sacks: hold_q.sacks, out_price: hold_q.price,
                    value_per_area: is_ins ? div_value : hold_q.value, last: 1'b1};
          if (stat_q == STAT_OK) begin
            if (is_ins) begin
              mem_we    = 1'b1;
              mem_waddr = pos_q[AW-1:0];
              mem_wdata = '{year: req_q.year, area: req_q.area_hundredths,
                            sacks: req_q.sack_count, price: req_q.sack_price_cents,
                            value: div_value};
              cnt_d     = cnt_q + 1'b1;
            end else begin
              cnt_d = cnt_q - 1'b1;
            end
          end
        end
      end
      S_DUMP_OUT: begin
        res_valid_d = 1'b1;
        res_d = '{status: STAT_OK, out_year: mem_rdata.year, out_area: mem_rdata.area,
                  out_sacks: mem_rdata.sacks, out_price: mem_rdata.price,
                  value_per_area: mem_rdata.value, last: last_rec};
        idx_d = idx_inc;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    idx_q  <= idx_d;
    pos_q  <= pos_d;
    stat_q <= stat_d;
    hold_q <= hold_d;
    res_q  <= res_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // checks
  `SKRT_ASSERT_IMP(a_cnt_in_range, 1'b1, cnt_q <= CW'(CAPACITY),
    "record count above capacity")
  `SKRT_ASSERT_IMP(a_cnt_moves_with_result, cnt_q != $past(cnt_q), res_valid_q,
    "record count changed without a result")
  `SKRT_ASSERT_IMP(a_div_free_on_start, div_start, !div_busy,
    "value unit started while still working")
  `SKRT_ASSERT_NXT(a_write_in_table, mem_we && state_q == S_SHWR, idx_q < CW'(CAPACITY),
    "shift walked outside the table")

endmodule

`default_nettype wire

[design/skrt_div.sv]
// ----------------------------------------------------------------------------
// skrt_div
// value per hectare unit: price * sacks * 100 / area, one quotient bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module skrt_div
  import skrt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [AREA_W-1:0]  area_i,
  input  logic [SACKS_W-1:0] sacks_i,
  input  logic [PRICE_W-1:0] price_i,
  output logic               busy_o,
  output logic [VAL_W-1:0]   value_o
);

  logic              busy_q, pre_q, zero_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [PROD_W-1:0] prod_q;
  logic [NUM_W-1:0]  num_q;
  logic [AREA_W:0]   rem_q;
  logic [AREA_W-1:0] area_q;

  logic [AREA_W:0]   rem_sh;
  logic              ge;
  logic [AREA_W:0]   rem_nx;

  // one restoring step
  always_comb begin
    rem_sh = {rem_q[AREA_W-1:0], num_q[NUM_W-1]};
    ge     = rem_sh >= {1'b0, area_q};
    rem_nx = ge ? (rem_sh - {1'b0, area_q}) : rem_sh;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pre_q  <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      pre_q  <= 1'b1;
      cnt_q  <= DCNT_W'(NUM_W);
    end else if (pre_q) begin
      pre_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DCNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // datapath: product, scale, then quotient shifted into the numerator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= PROD_W'(price_i) * PROD_W'(sacks_i);
      area_q <= area_i;
      zero_q <= (area_i == '0);
    end else if (pre_q) begin
      num_q <= {{SCALE_W{1'b0}}, prod_q} * NUM_W'(SCALE);
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], ge};
      rem_q <= rem_nx;
    end
  end

  // saturate at the top of the value field
  always_comb begin
    if (zero_q) begin
      value_o = '0;
    end else if (|num_q[NUM_W-1:VAL_W]) begin
      value_o = '1;
    end else begin
      value_o = num_q[VAL_W-1:0];
    end
  end

  assign busy_o = busy_q;

endmodule

`default_nettype wire

[design/skrt_store.sv]
// ----------------------------------------------------------------------------
// skrt_store
// record memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module skrt_store
  import skrt_pkg::*;
#(
  parameter int unsigned DEPTH = CAPACITY_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  rec_t          wdata_i,
  input  logic [AW-1:0] raddr_i,
  output rec_t          rdata_o
);

  rec_t mem [DEPTH];
  rec_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
